// ===== sv/grid_dijkstra_planner_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid planner
// Clocked assertion forms used by the planner top module.
// ----------------------------------------------------------------------------
`ifndef GRID_DIJKSTRA_PLANNER_TOP_ASSERT_SVH
`define GRID_DIJKSTRA_PLANNER_TOP_ASSERT_SVH

// Checked only while out of reset.
`define GDP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define GDP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/gdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid planner package
// Command codes, register indexes, field widths and the move table.
// ----------------------------------------------------------------------------
`default_nettype none

package gdp_pkg;

  localparam int STEP_W     = 10;
  localparam int FIELD_W    = 6;
  localparam int RES_COST_W = 24;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic CFG_STRAIGHT = 1'b0;
  localparam logic CFG_DIAG     = 1'b1;

  // Moves in search order; first four are axis moves.
  localparam logic signed [1:0] MOVE_DX [8] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                               -2'sd1, -2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] MOVE_DY [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                               -2'sd1, 2'sd1, -2'sd1, 2'sd1};

endpackage

`default_nettype wire

// ===== sv/gdp_relax.sv =====
// ----------------------------------------------------------------------------
// Grid planner cost unit
// Saturating add of a step to a base cost and strict compare with a reference.
// ----------------------------------------------------------------------------
`default_nettype none

module gdp_relax #(
  parameter int COST_BITS = 24
) (
  input  wire logic [COST_BITS-1:0]     base_i,
  input  wire logic [gdp_pkg::STEP_W-1:0] step_i,
  input  wire logic [COST_BITS-1:0]     ref_i,
  output logic      [COST_BITS-1:0]     sum_o,
  output logic                          lt_o
);

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  logic [COST_BITS:0] wide_sum;

  always_comb begin
    wide_sum = {1'b0, base_i} + (COST_BITS + 1)'(step_i);
    // clamp just below the unreachable mark
    if (wide_sum >= {1'b0, COST_INF}) begin
      sum_o = COST_INF - COST_BITS'(1);
    end else begin
      sum_o = wide_sum[COST_BITS-1:0];
    end
    lt_o = sum_o < ref_i;
  end

endmodule

`default_nettype wire

// ===== sv/grid_dijkstra_planner_top.sv =====
// ----------------------------------------------------------------------------
// Grid shortest-path planner
// 8-connected Dijkstra search over an obstacle grid with path readout.
// ----------------------------------------------------------------------------
// One item is taken at a time. A search first sweeps the cost store, then for
// each expanded cell scans the whole store for the cheapest open cell through
// the single read port and relaxes up to eight neighbours. After reset the
// obstacle store is swept clear, during which no item is taken; configuration
// writes are taken at any time.
`default_nettype none

module grid_dijkstra_planner_top #(
  parameter int GRID_SIDE = 64,
  parameter int COST_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cell_x[5:0], cell_y[11:6], goal_x[17:12], goal_y[23:18], blocked[24]
  input  wire logic [31:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // path_row[5:0], path_col[11:6], path_cost[35:12]
  output logic [39:0]      m_axis_tdata,
  // path_last
  output logic             m_axis_tlast,
  // found[0], path_valid[1]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [9:0]  cfg_data_i
);

  localparam int CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int COORD_W = $clog2(GRID_SIDE);
  localparam int SIDE_W  = COORD_W + 1;
  localparam int NODE_W  = COST_BITS + 2;
  localparam int RC_W    = gdp_pkg::RES_COST_W;
  localparam int FW      = gdp_pkg::FIELD_W;

  localparam logic [COST_BITS-1:0] COST_INF  = {COST_BITS{1'b1}};
  localparam logic [COORD_W-1:0]   LAST_CRD  = COORD_W'(GRID_SIDE - 1);
  localparam logic [SIDE_W-1:0]    SIDE_LIM  = SIDE_W'(GRID_SIDE);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CLR    = 4'd2;
  localparam logic [3:0] ST_START  = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_TAIL   = 4'd5;
  localparam logic [3:0] ST_DECIDE = 4'd6;
  localparam logic [3:0] ST_MARK   = 4'd7;
  localparam logic [3:0] ST_NADDR  = 4'd8;
  localparam logic [3:0] ST_NEVAL  = 4'd9;
  localparam logic [3:0] ST_RDWAIT = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  function automatic logic [IDX_W-1:0] cell_idx(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
    return IDX_W'(x) * IDX_W'(GRID_SIDE) + IDX_W'(y);
  endfunction

  function automatic logic coord_ok(input logic [FW-1:0] v);
    return 32'(v) < 32'(GRID_SIDE);
  endfunction

  function automatic logic [SIDE_W-1:0] move(input logic [COORD_W-1:0] c,
                                             input logic signed [1:0] m,
                                             input logic back);
    logic [SIDE_W-1:0] ext;
    ext = {{(SIDE_W-2){m[1]}}, m};
    return back ? ({1'b0, c} - ext) : ({1'b0, c} + ext);
  endfunction

  // stores
  logic [NODE_W-1:0] node_mem [CELLS];
  logic [2:0]        par_mem  [CELLS];
  logic              obs_mem  [CELLS];
  logic [NODE_W-1:0] node_rd_q;
  logic [2:0]        par_rd_q;
  logic              obs_rd_q;

  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              node_we, par_we, obs_we;
  logic [NODE_W-1:0] node_wdata;
  logic [2:0]        par_wdata;
  logic              obs_wdata;

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[wr_addr] <= node_wdata;
    if (par_we) par_mem[wr_addr] <= par_wdata;
    if (obs_we) obs_mem[wr_addr] <= obs_wdata;
    node_rd_q <= node_mem[rd_addr];
    par_rd_q  <= par_mem[rd_addr];
    obs_rd_q  <= obs_mem[rd_addr];
  end

  logic [COST_BITS-1:0] node_cost;
  logic                 node_vis, node_open;
  assign node_cost = node_rd_q[COST_BITS-1:0];
  assign node_vis  = node_rd_q[COST_BITS];
  assign node_open = node_rd_q[COST_BITS+1];

  // control and payload registers
  logic [3:0]           state_q, state_d;
  logic [COORD_W-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [COORD_W-1:0]   bx_q, bx_d, by_q, by_d;
  logic [COST_BITS-1:0] bcost_q, bcost_d;
  logic                 have_q, have_d;
  logic [COORD_W-1:0]   gx_q, gx_d, gy_q, gy_d;
  logic [2:0]           d_q, d_d;
  logic [COORD_W-1:0]   nx_q, nx_d, ny_q, ny_d;
  logic                 bad_q, bad_d;
  logic [COORD_W-1:0]   stx_q, stx_d, sty_q, sty_d;
  logic [COORD_W-1:0]   curx_q, curx_d, cury_q, cury_d;
  logic                 cfull_q, cfull_d;
  logic                 found_q, found_d;
  logic                 sv_q, sv_d;
  logic [COORD_W-1:0]   spx_q, spx_d, spy_q, spy_d;
  logic [gdp_pkg::STEP_W-1:0] straight_q, straight_d, diag_q, diag_d;
  logic [RC_W-1:0]      rcost_q, rcost_d;
  logic [FW-1:0]        rrow_q, rrow_d, rcol_q, rcol_d;
  logic                 rlast_q, rlast_d, rpv_q, rpv_d;
  logic                 mval_q, mval_d;
  logic [39:0]          mdata_q, mdata_d;
  logic                 mlast_q, mlast_d;
  logic [1:0]           muser_q, muser_d;

  // shared cost unit
  logic [COST_BITS-1:0]       alu_base, alu_ref, alu_sum;
  logic [gdp_pkg::STEP_W-1:0] alu_step;
  logic                       alu_lt;

  gdp_relax #(.COST_BITS(COST_BITS)) u_relax (
    .base_i (alu_base),
    .step_i (alu_step),
    .ref_i  (alu_ref),
    .sum_o  (alu_sum),
    .lt_o   (alu_lt)
  );

  logic                sweep_last;
  logic [SIDE_W-1:0]   nxw, nyw, pxw, pyw;
  logic [1:0]          in_cmd;
  logic [FW-1:0]       in_x, in_y, in_gx, in_gy;
  logic                in_blk;

  assign in_cmd = s_axis_tuser;
  assign in_x   = s_axis_tdata[5:0];
  assign in_y   = s_axis_tdata[11:6];
  assign in_gx  = s_axis_tdata[17:12];
  assign in_gy  = s_axis_tdata[23:18];
  assign in_blk = s_axis_tdata[24];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tlast  = mlast_q;
  assign m_axis_tuser  = muser_q;

  assign sweep_last = (cx_q == LAST_CRD) && (cy_q == LAST_CRD);
  assign nxw = move(bx_q, gdp_pkg::MOVE_DX[d_q], 1'b0);
  assign nyw = move(by_q, gdp_pkg::MOVE_DY[d_q], 1'b0);
  assign pxw = move(curx_q, gdp_pkg::MOVE_DX[par_rd_q], 1'b1);
  assign pyw = move(cury_q, gdp_pkg::MOVE_DY[par_rd_q], 1'b1);

  always_comb begin
    if (sv_q) begin
      alu_base = node_cost;
      alu_step = '0;
      alu_ref  = bcost_q;
    end else begin
      alu_base = bcost_q;
      alu_step = d_q[2] ? diag_q : straight_q;
      alu_ref  = node_cost;
    end
  end

  always_comb begin
    state_d = state_q;
    cx_d = cx_q;   cy_d = cy_q;
    bx_d = bx_q;   by_d = by_q;
    bcost_d = bcost_q;
    have_d = have_q;
    gx_d = gx_q;   gy_d = gy_q;
    d_d = d_q;
    nx_d = nx_q;   ny_d = ny_q;
    bad_d = bad_q;
    stx_d = stx_q; sty_d = sty_q;
    curx_d = curx_q; cury_d = cury_q;
    cfull_d = cfull_q;
    found_d = found_q;
    sv_d  = (state_q == ST_SCAN);
    spx_d = cx_q;  spy_d = cy_q;
    straight_d = straight_q;
    diag_d = diag_q;
    rcost_d = rcost_q; rrow_d = rrow_q; rcol_d = rcol_q;
    rlast_d = rlast_q; rpv_d = rpv_q;
    mval_d  = mval_q && !m_axis_tready;
    mdata_d = mdata_q; mlast_d = mlast_q; muser_d = muser_q;

    rd_addr    = cell_idx(cx_q, cy_q);
    wr_addr    = cell_idx(cx_q, cy_q);
    node_we    = 1'b0;
    par_we     = 1'b0;
    obs_we     = 1'b0;
    node_wdata = {2'b00, COST_INF};
    par_wdata  = d_q;
    obs_wdata  = 1'b0;

    if (cfg_valid_i) begin
      if (cfg_index_i == gdp_pkg::CFG_STRAIGHT) straight_d = cfg_data_i;
      else diag_d = cfg_data_i;
    end

    // scan pipeline: keep the cheapest open, unvisited cell (first wins ties)
    if (sv_q && node_open && !node_vis && (!have_q || alu_lt)) begin
      bx_d = spx_q;
      by_d = spy_q;
      bcost_d = node_cost;
      have_d = 1'b1;
    end

    case (state_q)
      ST_INIT: begin
        obs_we = 1'b1;
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          rcost_d = '0; rrow_d = '0; rcol_d = '0; rlast_d = 1'b0; rpv_d = 1'b0;
          case (in_cmd)
            gdp_pkg::CMD_SEARCH: begin
              found_d = 1'b0;
              cfull_d = 1'b0;
              bad_d = !(coord_ok(in_x) && coord_ok(in_y) &&
                        coord_ok(in_gx) && coord_ok(in_gy));
              bx_d = COORD_W'(in_x);  by_d = COORD_W'(in_y);
              gx_d = COORD_W'(in_gx); gy_d = COORD_W'(in_gy);
              cx_d = '0; cy_d = '0;
              state_d = ST_CLR;
            end
            gdp_pkg::CMD_READ: begin
              if (cfull_q) begin
                rd_addr = cell_idx(curx_q, cury_q);
                state_d = ST_RDWAIT;
              end else begin
                state_d = ST_OUT;
              end
            end
            default: begin
              if (in_cmd == gdp_pkg::CMD_WRITE && coord_ok(in_x) && coord_ok(in_y)) begin
                obs_we    = 1'b1;
                wr_addr   = cell_idx(COORD_W'(in_x), COORD_W'(in_y));
                obs_wdata = in_blk;
              end
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_CLR: begin
        node_we = 1'b1;
        if (sweep_last) begin
          if (bad_q) begin
            rcost_d = RC_W'(COST_INF);
            state_d = ST_OUT;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        node_we    = 1'b1;
        wr_addr    = cell_idx(bx_q, by_q);
        node_wdata = {2'b10, {COST_BITS{1'b0}}};
        stx_d = bx_q;
        sty_d = by_q;
        cx_d = '0; cy_d = '0; have_d = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sweep_last) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!have_q) begin
          rcost_d = RC_W'(COST_INF);
          state_d = ST_OUT;
        end else if (bx_q == gx_q && by_q == gy_q) begin
          found_d = 1'b1;
          cfull_d = 1'b1;
          curx_d = gx_q;
          cury_d = gy_q;
          rcost_d = RC_W'(bcost_q);
          state_d = ST_OUT;
        end else begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        node_we    = 1'b1;
        wr_addr    = cell_idx(bx_q, by_q);
        node_wdata = {2'b11, bcost_q};
        d_d = '0;
        state_d = ST_NADDR;
      end
      ST_NADDR: begin
        nx_d = nxw[COORD_W-1:0];
        ny_d = nyw[COORD_W-1:0];
        rd_addr = cell_idx(nxw[COORD_W-1:0], nyw[COORD_W-1:0]);
        if (nxw < SIDE_LIM && nyw < SIDE_LIM) begin
          state_d = ST_NEVAL;
        end else if (d_q == 3'd7) begin
          cx_d = '0; cy_d = '0; have_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          d_d = d_q + 3'd1;
        end
      end
      ST_NEVAL: begin
        wr_addr = cell_idx(nx_q, ny_q);
        if (!node_vis && !obs_rd_q) begin
          node_we    = 1'b1;
          node_wdata = {2'b10, alu_lt ? alu_sum : node_cost};
          par_we     = alu_lt;
        end
        if (d_q == 3'd7) begin
          cx_d = '0; cy_d = '0; have_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          d_d = d_q + 3'd1;
          state_d = ST_NADDR;
        end
      end
      ST_RDWAIT: begin
        rrow_d  = FW'(curx_q);
        rcol_d  = FW'(cury_q);
        rcost_d = RC_W'(node_cost);
        rpv_d   = 1'b1;
        rlast_d = (curx_q == stx_q) && (cury_q == sty_q);
        if (rlast_d || pxw >= SIDE_LIM || pyw >= SIDE_LIM) begin
          cfull_d = 1'b0;
        end else begin
          curx_d = pxw[COORD_W-1:0];
          cury_d = pyw[COORD_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold the result until the output register is free
        if (!mval_q || m_axis_tready) begin
          mval_d  = 1'b1;
          mdata_d = {4'b0000, rcost_q, rcol_q, rrow_q};
          mlast_d = rlast_q;
          muser_d = {rpv_q, found_q};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // advance the sweep counter during sweeps
    if (state_q == ST_INIT || state_q == ST_CLR || state_q == ST_SCAN) begin
      if (cy_q == LAST_CRD) begin
        cy_d = '0;
        cx_d = cx_q + COORD_W'(1);
      end else begin
        cy_d = cy_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cx_q <= '0;   cy_q <= '0;
      bx_q <= '0;   by_q <= '0;
      bcost_q <= '0;
      have_q <= 1'b0;
      gx_q <= '0;   gy_q <= '0;
      d_q <= '0;
      nx_q <= '0;   ny_q <= '0;
      bad_q <= 1'b0;
      stx_q <= '0;  sty_q <= '0;
      curx_q <= '0; cury_q <= '0;
      cfull_q <= 1'b0;
      found_q <= 1'b0;
      sv_q <= 1'b0;
      spx_q <= '0;  spy_q <= '0;
      straight_q <= gdp_pkg::STEP_W'(256);
      diag_q <= gdp_pkg::STEP_W'(362);
      rcost_q <= '0; rrow_q <= '0; rcol_q <= '0;
      rlast_q <= 1'b0; rpv_q <= 1'b0;
      mval_q <= 1'b0;
      mdata_q <= '0; mlast_q <= 1'b0; muser_q <= '0;
    end else begin
      state_q <= state_d;
      cx_q <= cx_d;   cy_q <= cy_d;
      bx_q <= bx_d;   by_q <= by_d;
      bcost_q <= bcost_d;
      have_q <= have_d;
      gx_q <= gx_d;   gy_q <= gy_d;
      d_q <= d_d;
      nx_q <= nx_d;   ny_q <= ny_d;
      bad_q <= bad_d;
      stx_q <= stx_d; sty_q <= sty_d;
      curx_q <= curx_d; cury_q <= cury_d;
      cfull_q <= cfull_d;
      found_q <= found_d;
      sv_q <= sv_d;
      spx_q <= spx_d; spy_q <= spy_d;
      straight_q <= straight_d;
      diag_q <= diag_d;
      rcost_q <= rcost_d; rrow_q <= rrow_d; rcol_q <= rcol_d;
      rlast_q <= rlast_d; rpv_q <= rpv_d;
      mval_q <= mval_d;
      mdata_q <= mdata_d; mlast_q <= mlast_d; muser_q <= muser_d;
    end
  end

`include "grid_dijkstra_planner_top_assert.svh"

  `GDP_ASSERT(a_cursor_needs_found, cfull_q |-> found_q, "path cursor set without a found search")
  `GDP_ASSERT(a_scan_pipe, sv_q |-> (state_q == ST_SCAN || state_q == ST_TAIL), "scan data outside scan")
  `GDP_ASSERT(a_eval_after_addr, state_q == ST_NEVAL |-> $past(state_q) == ST_NADDR, "neighbour eval without address")
  `GDP_ASSERT_ALWAYS(a_no_take_in_reset, !rst_ni |-> s_axis_tready !== 1'b1, "item taken during reset")

endmodule

`default_nettype wire

// ===== bench/grid_dijkstra_planner_top_tb.sv =====
// ----------------------------------------------------------------------------
// Grid planner regression bench
// Drives obstacle writes, searches and path readouts into the planner through
// its item stream and checks every result against an in-bench planner model.
// The searches are kept inside a walled 3x3 pocket so each one stays short.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_dijkstra_planner_top_tb;

  localparam int          SIDE       = 64;
  localparam int          CELLS      = SIDE * SIDE;
  localparam logic [23:0] COST_INF   = 24'hFFFFFF;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  // Pocket interior spans rows and columns 1..3; rows/cols 0 and 4 form the wall.
  localparam int          POCKET_LO  = 1;
  localparam int          POCKET_HI  = 3;

  typedef struct packed {
    logic        found;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [23:0] cost;
    logic        last;
    logic        valid;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = gdp_pkg::CMD_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = gdp_pkg::CFG_STRAIGHT;
  logic [9:0]  cfg_data_i = '0;

  grid_dijkstra_planner_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Planner model state
  logic [9:0]  straight_cost = 10'd256;
  logic [9:0]  diag_cost     = 10'd362;
  logic        obstacle [CELLS];
  logic [23:0] cell_cost [CELLS];
  logic        visited [CELLS];
  logic        opened [CELLS];
  logic [2:0]  parent_dir [CELLS];
  int          cursor;
  logic        cursor_full;
  logic        goal_found;
  int          start_cell;

  reply_t pending_replies [$];
  int     err_count;
  int     items_sent;
  int     searches_sent;
  int     reads_sent;
  int     burst_left;

  function automatic void run_search(int sx, int sy, int gx, int gy);
    int goal, best, nx, ny, nb;
    logic [23:0] bcost;
    logic [24:0] sum;
    for (int i = 0; i < CELLS; i++) begin
      cell_cost[i] = COST_INF;
      visited[i]   = 1'b0;
      opened[i]    = 1'b0;
    end
    goal_found  = 1'b0;
    cursor_full = 1'b0;
    start_cell  = sx * SIDE + sy;
    goal        = gx * SIDE + gy;
    cell_cost[start_cell] = '0;
    opened[start_cell]    = 1'b1;
    forever begin
      best  = CELLS;
      bcost = '0;
      for (int i = 0; i < CELLS; i++) begin
        if (opened[i] && !visited[i] && (best == CELLS || cell_cost[i] < bcost)) begin
          best  = i;
          bcost = cell_cost[i];
        end
      end
      if (best == CELLS) return;
      visited[best] = 1'b1;
      if (best == goal) begin
        goal_found  = 1'b1;
        cursor      = goal;
        cursor_full = 1'b1;
        return;
      end
      for (int d = 0; d < 8; d++) begin
        nx = best / SIDE + int'(gdp_pkg::MOVE_DX[d]);
        ny = best % SIDE + int'(gdp_pkg::MOVE_DY[d]);
        if (nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE) continue;
        nb = nx * SIDE + ny;
        if (visited[nb] || obstacle[nb]) continue;
        sum = bcost + ((d < 4) ? straight_cost : diag_cost);
        if (sum > {1'b0, COST_INF - 24'd1}) sum = {1'b0, COST_INF - 24'd1};
        if (sum[23:0] < cell_cost[nb]) begin
          cell_cost[nb]  = sum[23:0];
          parent_dir[nb] = 3'(d);
        end
        opened[nb] = 1'b1;
      end
    end
  endfunction

  function automatic reply_t planner_reply(logic [1:0] cmd, int x, int y, int gx, int gy,
                                           logic blk);
    reply_t r;
    int px, py;
    r = '0;
    if (cmd == gdp_pkg::CMD_WRITE) begin
      obstacle[x * SIDE + y] = blk;
    end else if (cmd == gdp_pkg::CMD_SEARCH) begin
      run_search(x, y, gx, gy);
      r.cost = goal_found ? cell_cost[gx * SIDE + gy] : COST_INF;
    end else if (cmd == gdp_pkg::CMD_READ && cursor_full) begin
      r.row   = 6'(cursor / SIDE);
      r.col   = 6'(cursor % SIDE);
      r.cost  = cell_cost[cursor];
      r.last  = (cursor == start_cell);
      r.valid = 1'b1;
      if (r.last) begin
        cursor_full = 1'b0;
      end else begin
        px = cursor / SIDE - int'(gdp_pkg::MOVE_DX[parent_dir[cursor]]);
        py = cursor % SIDE - int'(gdp_pkg::MOVE_DY[parent_dir[cursor]]);
        if (px < 0 || py < 0 || px >= SIDE || py >= SIDE) cursor_full = 1'b0;
        else cursor = px * SIDE + py;
      end
    end
    r.found = goal_found;
    return r;
  endfunction

  task automatic send_item(logic [1:0] cmd, int x, int y, int gx, int gy, logic blk);
    s_axis_tdata  <= {7'b0, blk, 6'(gy), 6'(gx), 6'(y), 6'(x)};
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(planner_reply(cmd, x, y, gx, gy, blk));
    items_sent++;
    if (cmd == gdp_pkg::CMD_SEARCH) searches_sent++;
    if (cmd == gdp_pkg::CMD_READ) reads_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_step_cost(logic idx, logic [9:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gdp_pkg::CFG_STRAIGHT) straight_cost = value;
    else diag_cost = value;
  endtask

  task automatic set_step_costs(logic [9:0] straight, logic [9:0] diag);
    wait_drained();
    write_step_cost(gdp_pkg::CFG_STRAIGHT, straight);
    write_step_cost(gdp_pkg::CFG_DIAG, diag);
  endtask

  task automatic read_path(int count);
    repeat (count) send_item(gdp_pkg::CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom));
  endtask

  // Receiver: stretches of full throughput mixed with random stalls.
  int stall_mode;
  int stall_run;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(5, 60);
    end
    stall_run--;
    m_axis_tready <= (stall_mode == 0) || ($urandom_range(0, stall_mode) == 0);
  end

  always @(posedge clk_i) begin
    reply_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("result with no item outstanding");
        err_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (m_axis_tuser[0] !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, m_axis_tuser[0]);
          err_count++;
        end
        if (m_axis_tdata[5:0] !== exp_r.row) begin
          $error("path_row: expected %0d, got %0d", exp_r.row, m_axis_tdata[5:0]);
          err_count++;
        end
        if (m_axis_tdata[11:6] !== exp_r.col) begin
          $error("path_col: expected %0d, got %0d", exp_r.col, m_axis_tdata[11:6]);
          err_count++;
        end
        if (m_axis_tdata[35:12] !== exp_r.cost) begin
          $error("path_cost: expected %0d, got %0d", exp_r.cost, m_axis_tdata[35:12]);
          err_count++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $error("path_last: expected %0d, got %0d", exp_r.last, m_axis_tlast);
          err_count++;
        end
        if (m_axis_tuser[1] !== exp_r.valid) begin
          $error("path_valid: expected %0d, got %0d", exp_r.valid, m_axis_tuser[1]);
          err_count++;
        end
      end
    end
  end

  // Wall cells around the pocket keep every search to at most nine expansions.
  task automatic test_pocket_walls();
    for (int x = 0; x <= POCKET_HI + 1; x++)
      for (int y = 0; y <= POCKET_HI + 1; y++)
        if (x < POCKET_LO || x > POCKET_HI || y < POCKET_LO || y > POCKET_HI)
          send_item(gdp_pkg::CMD_WRITE, x, y, 63, 63, 1'b1);
  endtask

  task automatic test_directed();
    read_path(1);                                   // readout before any search
    send_item(CMD_UNUSED, 63, 63, 63, 63, 1'b1);    // undefined command
    send_item(gdp_pkg::CMD_WRITE, 63, 63, 0, 0, 1'b1);
    send_item(gdp_pkg::CMD_WRITE, 63, 63, 63, 63, 1'b0);
    send_item(gdp_pkg::CMD_SEARCH, 1, 1, 3, 3, 1'b0);
    read_path(4);                                   // full walk, then empty
    send_item(gdp_pkg::CMD_WRITE, 2, 2, 0, 0, 1'b1);
    send_item(gdp_pkg::CMD_SEARCH, 2, 2, 2, 2, 1'b0);  // blocked start that is the goal
    read_path(2);
    send_item(gdp_pkg::CMD_SEARCH, 1, 1, 2, 2, 1'b0);  // blocked goal
    send_item(gdp_pkg::CMD_SEARCH, 3, 1, 63, 0, 1'b0); // goal outside the pocket
    read_path(1);
    send_item(gdp_pkg::CMD_WRITE, 2, 2, 0, 0, 1'b0);
  endtask

  task automatic test_step_costs();
    logic [9:0] costs [5][2] = '{'{10'd1, 10'd1023}, '{10'd1023, 10'd1}, '{10'd1, 10'd1},
                                 '{10'd1023, 10'd1023}, '{10'd256, 10'd362}};
    for (int p = 0; p < 5; p++) begin
      set_step_costs(costs[p][0], costs[p][1]);
      send_item(gdp_pkg::CMD_SEARCH, 1, 1, 3, 3, 1'b0);
      read_path(4);
      send_item(gdp_pkg::CMD_SEARCH, 3, 2, 1, 1, 1'b0);
      read_path(4);
    end
  endtask

  task automatic test_random_traffic(int count);
    int x, y, sel;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 24)
        set_step_costs(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)));
      sel = $urandom_range(0, 99);
      x = $urandom_range(0, 63);
      y = $urandom_range(0, 63);
      if (sel < 30) begin
        if ($urandom_range(0, 9) < 7)
          send_item(gdp_pkg::CMD_SEARCH, $urandom_range(POCKET_LO, POCKET_HI),
                    $urandom_range(POCKET_LO, POCKET_HI),
                    $urandom_range(POCKET_LO, POCKET_HI),
                    $urandom_range(POCKET_LO, POCKET_HI), 1'($urandom));
        else
          send_item(gdp_pkg::CMD_SEARCH, $urandom_range(POCKET_LO, POCKET_HI),
                    $urandom_range(POCKET_LO, POCKET_HI), x, y, 1'($urandom));
      end else if (sel < 70) begin
        read_path(1);
      end else if (sel < 95) begin
        // Keep the wall intact: fold wall hits into the pocket.
        if (x <= POCKET_HI + 1 && y <= POCKET_HI + 1) begin
          x = POCKET_LO + x % 3;
          y = POCKET_LO + y % 3;
          send_item(gdp_pkg::CMD_WRITE, x, y, $urandom_range(0, 63), $urandom_range(0, 63),
                    ($urandom_range(0, 3) == 0));
        end else begin
          send_item(gdp_pkg::CMD_WRITE, x, y, $urandom_range(0, 63), $urandom_range(0, 63),
                    1'($urandom));
        end
      end else begin
        send_item(CMD_UNUSED, x, y, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom));
      end
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      obstacle[i]   = 1'b0;
      cell_cost[i]  = COST_INF;
      visited[i]    = 1'b0;
      opened[i]     = 1'b0;
      parent_dir[i] = '0;
    end
    cursor        = 0;
    cursor_full   = 1'b0;
    goal_found    = 1'b0;
    start_cell    = 0;
    err_count     = 0;
    items_sent    = 0;
    searches_sent = 0;
    reads_sent    = 0;
    burst_left    = 0;
    stall_run     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pocket_walls();
    test_directed();
    test_step_costs();
    test_random_traffic(25);
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items: %0d searches, %0d path reads, under several step costs.",
             items_sent, searches_sent, reads_sent);
    if (err_count == 0) $display("grid_dijkstra_planner_top regression: pass");
    else $display("grid_dijkstra_planner_top regression: fail");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("grid_dijkstra_planner_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
